// ----- rtl/temporal_plane_blend_defines.svh -----
// assertion macros for the temporal plane blend
`ifndef TEMPORAL_PLANE_BLEND_DEFINES_SVH
`define TEMPORAL_PLANE_BLEND_DEFINES_SVH

// same-cycle implication, held off while in reset
`define TPB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tpb assertion failed");

// next-cycle implication, held off while in reset
`define TPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tpb assertion failed");

`endif

// ----- rtl/tpb_pkg.sv -----
// shared constants and types of the temporal plane blend
`timescale 1ns / 1ps
`default_nettype none

package tpb_pkg;

  localparam int PLANE_COUNT  = 64;
  localparam int PLANE_W      = $clog2(PLANE_COUNT);
  localparam int PIX_W        = 6;
  localparam int FRAME_PIXELS = 4096;
  localparam int POS_W        = $clog2(FRAME_PIXELS);
  localparam int WORD_W       = PLANE_COUNT * PIX_W;
  localparam int OFF_W        = $clog2(WORD_W);
  localparam int LUMA_W       = 8;
  localparam int STRIDE_W     = 5;
  localparam int TAPS         = 4;
  localparam int FIFO_DEPTH   = 3;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(8);

  typedef enum logic {
    CFG_PLANE_STRIDE  = 1'b0,
    CFG_FEEDBACK_MODE = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic              last;
  } out_beat_t;

endpackage

`default_nettype wire

// ----- rtl/tpb_ram.sv -----
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none

module tpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/temporal_plane_blend.sv -----
// temporal plane blend: per-pixel average over a ring of past frame planes
//
// usage:
//   s_axis carries one luma pixel per beat in raster order, tlast on the
//   last pixel of a frame. m_axis returns one blended pixel per beat in the
//   same order, tlast copied through. cfg writes plane_stride (index 0) and
//   feedback_mode (index 1); cfg_ready_o is always high, write only when idle.
//   all 64 planes of a pixel position share one 384-bit word of a
//   4096-entry ram: one read and one write-back per pixel.
//   path: an accepted pixel passes the stage 1 registers and the registered
//   ram read, then the output queue, from which m_axis presents it.
//   throughput: one pixel per clock unless stalled, set by the single ram read
//   and write port pair; back-to-back beats at the same position use a forwarded word.
//   reset: counters clear, plane_stride returns to 8, feedback_mode to 0, and
//   a clearing pass zeroes all 4096 ram words, one word a cycle, during
//   which s_axis_tready stays low.
//   stall: a three-beat output queue absorbs results; s_axis_tready drops
//   only when the pipeline and the queue hold three beats, or while clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "temporal_plane_blend_defines.svh"

module temporal_plane_blend
  import tpb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [STRIDE_W-1:0] cfg_data_i,
  // pixel input
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [LUMA_W-1:0]   s_axis_tdata,  // [7:0] luma_in
  input  wire logic                s_axis_tlast,  // last_pixel
  // pixel output
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [LUMA_W-1:0]   m_axis_tdata,  // [7:0] luma_out
  output logic                     m_axis_tlast   // last_pixel_out
);

  // configuration
  logic [STRIDE_W-1:0] stride_q;
  logic                mode_q;

  // frame counters and clear sweep
  logic [PLANE_W-1:0]  plane_q;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                clr_busy_q;
  logic [POS_W-1:0]    clr_addr_q;

  // stage 1
  logic                s1_valid_q;
  logic [LUMA_W-1:0]   s1_luma_q;
  logic                s1_last_q;
  logic [PLANE_W-1:0]  s1_plane_q;
  logic [POS_W-1:0]    s1_pos_q;
  logic [PLANE_W-1:0]  tap_q [TAPS];
  logic [PLANE_W-1:0]  tap_d [TAPS];
  logic                fwd_q;
  logic [WORD_W-1:0]   fwd_word_q;

  // output queue
  out_beat_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   count_q;

  logic                in_beat, out_beat;
  logic [PLANE_W-1:0]  mask, cf;
  logic [WORD_W-1:0]   rdata, base_word, mod_word, new_word;
  logic [OFF_W-1:0]    cp_off;
  logic [LUMA_W-1:0]   sum;
  logic [PIX_W-1:0]    keep_val;
  logic                ram_we;
  logic [POS_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [FIFO_CNT_W:0] in_flight;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_RESET;
      mode_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_PLANE_STRIDE:  stride_q <= cfg_data_i;
        CFG_FEEDBACK_MODE: mode_q   <= cfg_data_i[0];
      endcase
    end
  end

  // accept control
  assign in_flight     = (FIFO_CNT_W+1)'(s1_valid_q) + (FIFO_CNT_W+1)'(count_q);
  assign s_axis_tready = !clr_busy_q && (in_flight < (FIFO_CNT_W+1)'(FIFO_DEPTH));
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = m_axis_tvalid && m_axis_tready;

  // tap planes from current plane and stride
  assign mask = PLANE_W'({1'b0, stride_q} - 6'(1));
  assign cf   = plane_q & mask;

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      tap_d[k] = PLANE_W'(cf + PLANE_W'(k * stride_q));
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (s_axis_tlast || pos_q == POS_W'(FRAME_PIXELS - 1)) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q    <= '0;
      pos_q      <= '0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + POS_W'(1);
        if (clr_addr_q == POS_W'(FRAME_PIXELS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_beat) begin
        pos_q <= pos_d;
        if (s_axis_tlast) begin
          plane_q <= plane_q + PLANE_W'(1);
        end
      end
      s1_valid_q <= in_beat;
      // write-back of stage 1 lands on the same edge as this read
      fwd_q      <= in_beat && s1_valid_q && (s1_pos_q == pos_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_luma_q  <= s_axis_tdata;
      s1_last_q  <= s_axis_tlast;
      s1_plane_q <= plane_q;
      s1_pos_q   <= pos_q;
      for (int k = 0; k < TAPS; k++) begin
        tap_q[k] <= tap_d[k];
      end
    end
    fwd_word_q <= new_word;
  end

  tpb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FRAME_PIXELS)
  ) u_plane_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_beat),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  // read-modify-write of one plane word
  assign base_word = fwd_q ? fwd_word_q : rdata;
  assign cp_off    = OFF_W'(s1_plane_q) * OFF_W'(PIX_W);

  always_comb begin
    mod_word = base_word;
    mod_word[cp_off +: PIX_W] = s1_luma_q[LUMA_W-1 -: PIX_W];
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + LUMA_W'(mod_word[OFF_W'(tap_q[k]) * OFF_W'(PIX_W) +: PIX_W]);
    end
    keep_val = mode_q ? s1_luma_q[LUMA_W-1 -: PIX_W] : sum[LUMA_W-1 -: PIX_W];
    new_word = mod_word;
    new_word[cp_off +: PIX_W] = keep_val;
  end

  assign ram_we    = clr_busy_q || s1_valid_q;
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_pos_q;
  assign ram_wdata = clr_busy_q ? '0 : new_word;

  // output queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (s1_valid_q) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                              : wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (out_beat) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                              : rd_ptr_q + FIFO_PTR_W'(1);
      end
      count_q <= count_q + FIFO_CNT_W'(s1_valid_q) - FIFO_CNT_W'(out_beat);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fifo_q[wr_ptr_q] <= '{luma: sum, last: s1_last_q};
    end
  end

  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q].luma;
  assign m_axis_tlast  = fifo_q[rd_ptr_q].last;

  `TPB_ASSERT_NOW(a_queue_room, clk_i, rst_ni, s1_valid_q, count_q != FIFO_CNT_W'(FIFO_DEPTH))
  `TPB_ASSERT_NEXT(a_beat_to_stage, clk_i, rst_ni, in_beat, s1_valid_q)
  `TPB_ASSERT_NOW(a_fwd_has_stage, clk_i, rst_ni, fwd_q, s1_valid_q && !clr_busy_q)
  `TPB_ASSERT_NOW(a_no_beat_in_clear, clk_i, rst_ni, clr_busy_q, !s1_valid_q && count_q == '0)

endmodule

`default_nettype wire
